// File: rtl/sm3_hash_engine_assert.svh
// Assertion macros shared by the SM3 engine.
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH
// implication that must hold whenever out of reset
`define SM3_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sm3 check failed");
// next-cycle implication
`define SM3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sm3 check failed");
`endif

// File: rtl/sm3_pkg.sv
// Package: SM3 constants, helper functions and controller types.
`default_nettype none
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_WORD = 32'h80000000;

    // W memory holds the 16-word block and the expanded W[16..67]
    localparam int W_DEPTH  = 68;
    localparam int CV_DEPTH = 8;

    typedef enum logic [3:0] {
        ST_IDLE,   // waiting for a message word
        ST_PAD,    // writing padding words
        ST_LOAD,   // loading chaining value into A..H
        ST_EXP,    // expansion of W[16..67]
        ST_RND,    // 64 rounds
        ST_FOLD,   // fold result into chaining value
        ST_OUT,    // present digest words
        ST_RDOUT   // digest read latency
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] k);
        logic [63:0] d;
        d = {x, x} << k;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h7380166f;
            3'd1: v = 32'h4914b2b9;
            3'd2: v = 32'h172442d7;
            3'd3: v = 32'hda8a0600;
            3'd4: v = 32'ha96f30bc;
            3'd5: v = 32'h163138aa;
            3'd6: v = 32'he38dee4d;
            default: v = 32'hb0fb0e4e;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// File: rtl/sm3_hash_engine.sv
// SM3 hash engine top level: input control, W memory, rounds and digest output.
// The engine takes one big-endian word per request; the word flagged tlast may carry
// 0..4 bytes and triggers padding and an eight-word digest on the output stream. Each
// accepted word is written into a 68-entry W memory. When a block of 16 words is
// complete the input stalls for the compression: loading A..H from the chaining value
// memory, expansion of W[16..67] (five reads of the single W read port plus one write
// per word), 64 rounds (two reads per round) and the fold, all paced by the single
// memory read port. Padding writes up to 17 words, with a second compression when the
// length does not fit. The digest then leaves one word at a time (read, load,
// handshake, the next word read only after the handshake), held while tready is low,
// and the input stays stalled until the eighth word is taken. The chaining value lives
// in an 8-entry memory flagged as IV after reset, so no clearing pass is needed.
`default_nettype none
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // message_word[31:0], byte_count[34:32], zeros
    input  wire logic        s_axis_tlast,  // last_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,  // digest_word[31:0], digest_index[34:32], zeros
    output logic             m_axis_tlast   // digest_last
);
    `include "sm3_hash_engine_assert.svh"

    t_state r_state, n_state;
    logic [3:0]   r_cnt;        // words in block
    logic [63:0]  r_len;
    logic [6:0]   r_idx, n_idx; // expansion index / round step
    logic [2:0]   r_ph;         // phase within a multi-read step
    logic [255:0] r_abcd;
    logic [31:0]  r_t0, r_t1;
    logic         r_lenhi;      // length high word is in place
    logic         r_pend;       // padding still owed for the current message
    logic         r_fin;        // compressing the final block
    logic         r_pextra;     // a full last word needs the 0x80 word
    logic [2:0]   r_oi;         // digest output index
    logic         r_ov;
    logic [31:0]  r_od;
    logic [2:0]   r_oidx;

    // W memory
    logic        w_we;
    logic [6:0]  w_wa, w_ra;
    logic [31:0] w_wd, w_rd;
    // chaining value memory
    logic        v_we;
    logic [2:0]  v_wa, v_ra;
    logic [31:0] v_wd, v_rd;
    logic        r_vinit;       // chaining value equals IV (reset / after digest)

    sm3_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_wmem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa), .i_wdata(w_wd),
        .i_raddr(w_ra), .o_rdata(w_rd));
    sm3_ram #(.WIDTH(32), .DEPTH(CV_DEPTH)) u_vmem (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));

    logic [31:0] v_eff;
    logic [2:0]  r_vra;
    assign v_eff = r_vinit ? iv_word(r_vra) : v_rd;

    // round datapath: W[j] in r_t0, W[j+4] on the read port
    logic [255:0] rnd_out;
    logic [5:0]   rnd_j;
    logic         rnd_last;
    assign rnd_j = r_idx[5:0];
    assign rnd_last = (r_state == ST_RND) && (r_idx == 7'd63) && (r_ph == 3'd2);
    sm3_round u_round (.i_abcd(r_abcd), .i_j(rnd_j), .i_w(r_t0), .i_wp(r_t0 ^ w_rd),
                       .o_abcd(rnd_out));

    // input decode: keep the valid bytes, append the pad bit after them unless all four are valid
    logic [31:0] in_word, last_val, mask, pad_bit;
    logic [2:0]  in_bc;
    logic        acc_in;
    always_comb begin
        in_word = s_axis_tdata[31:0];
        in_bc   = (s_axis_tdata[34:32] > 3'd4) ? 3'd4 : s_axis_tdata[34:32];
        case (in_bc)
            3'd0: begin mask = 32'h0;        pad_bit = 32'h80000000; end
            3'd1: begin mask = 32'hff000000; pad_bit = 32'h00800000; end
            3'd2: begin mask = 32'hffff0000; pad_bit = 32'h00008000; end
            3'd3: begin mask = 32'hffffff00; pad_bit = 32'h00000080; end
            default: begin mask = 32'hffffffff; pad_bit = 32'h0; end
        endcase
        last_val = (in_word & mask) | pad_bit;
    end
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc_in = s_axis_tvalid && s_axis_tready;

    // padding word for slot r_cnt
    logic [31:0] pad_val;
    always_comb begin
        if (r_pextra) pad_val = PAD_WORD;
        else if (r_cnt == 4'd14) pad_val = r_len[63:32];
        else if (r_cnt == 4'd15 && r_lenhi) pad_val = r_len[31:0];
        else pad_val = 32'h0;
    end

    // next state and step counters
    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        unique case (r_state)
            ST_IDLE: if (acc_in) begin
                if (r_cnt == 4'd15) begin
                    n_state = ST_LOAD; n_idx = 7'd0;
                end else if (s_axis_tlast) n_state = ST_PAD;
            end
            ST_PAD: if (r_cnt == 4'd15) begin
                n_state = ST_LOAD; n_idx = 7'd0;
            end
            ST_LOAD: begin
                n_idx = r_idx + 7'd1;
                if (r_idx == 7'd8) begin n_state = ST_EXP; n_idx = 7'd16; end
            end
            ST_EXP: if (r_ph == 3'd5) begin
                n_idx = r_idx + 7'd1;
                if (r_idx == 7'd67) begin n_state = ST_RND; n_idx = 7'd0; end
            end
            ST_RND: if (r_ph == 3'd2) begin
                n_idx = r_idx + 7'd1;
                if (r_idx == 7'd63) begin n_state = ST_FOLD; n_idx = 7'd0; end
            end
            ST_FOLD: begin
                n_idx = r_idx + 7'd1;
                if (r_idx == 7'd8) begin
                    n_idx = 7'd0;
                    if (r_fin) n_state = ST_RDOUT;
                    else if (r_pend) n_state = ST_PAD;
                    else n_state = ST_IDLE;
                end
            end
            ST_RDOUT: n_state = ST_OUT;
            ST_OUT: if (r_ov && m_axis_tready) begin
                n_state = (r_oi == 3'd7) ? ST_IDLE : ST_RDOUT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory control and datapath outputs
    always_comb begin
        w_we = 1'b0; w_wa = {3'd0, r_cnt}; w_wd = 32'h0; w_ra = 7'd0;
        v_we = 1'b0; v_wa = 3'd0; v_wd = 32'h0; v_ra = 3'd0;
        unique case (r_state)
            ST_IDLE: begin
                w_we = acc_in;
                w_wd = s_axis_tlast ? last_val : in_word;
            end
            ST_PAD: begin
                w_we = 1'b1; w_wd = pad_val;
            end
            ST_LOAD: v_ra = r_idx[2:0];
            ST_EXP: begin
                // read W[j-16], W[j-9], W[j-3], W[j-13], W[j-6]; write W[j]
                case (r_ph)
                    3'd0: w_ra = r_idx - 7'd16;
                    3'd1: w_ra = r_idx - 7'd9;
                    3'd2: w_ra = r_idx - 7'd3;
                    3'd3: w_ra = r_idx - 7'd13;
                    3'd4: w_ra = r_idx - 7'd6;
                    default: w_ra = 7'd0;
                endcase
                w_we = (r_ph == 3'd5);
                w_wa = r_idx;
                w_wd = r_t0 ^ r_t1 ^ w_rd;
            end
            ST_RND: w_ra = (r_ph == 3'd0) ? r_idx : r_idx + 7'd4;
            ST_FOLD: begin
                v_ra = r_idx[2:0];
                v_we = (r_idx != 7'd0);
                v_wa = r_vra;
                v_wd = v_eff ^ r_abcd[{~r_vra, 5'd0} +: 32];
            end
            ST_RDOUT, ST_OUT: v_ra = r_oi;
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_cnt <= 4'd0; r_len <= 64'd0; r_idx <= 7'd0;
            r_ph <= 3'd0; r_lenhi <= 1'b0; r_pend <= 1'b0; r_fin <= 1'b0;
            r_oi <= 3'd0; r_ov <= 1'b0; r_vinit <= 1'b1; r_pextra <= 1'b0;
            r_abcd <= 256'd0; r_t0 <= 32'h0; r_t1 <= 32'h0; r_vra <= 3'd0;
            r_od <= 32'h0; r_oidx <= 3'd0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_vra <= v_ra;
            unique case (r_state)
                ST_IDLE: if (acc_in) begin
                    r_cnt <= r_cnt + 4'd1;
                    r_len <= r_len + (s_axis_tlast ? {58'd0, in_bc, 3'd0} : 64'd32);
                    if (s_axis_tlast) begin
                        r_pend   <= 1'b1;
                        r_pextra <= (in_bc == 3'd4);
                    end
                end
                ST_PAD: begin
                    r_cnt <= r_cnt + 4'd1;
                    r_pextra <= 1'b0;
                    if (r_cnt == 4'd14 && !r_pextra) r_lenhi <= 1'b1;
                    // length low word closes the final block
                    if (r_cnt == 4'd15 && r_lenhi) begin
                        r_fin  <= 1'b1;
                        r_pend <= 1'b0;
                    end
                end
                ST_LOAD: if (r_idx != 7'd0) begin
                    r_abcd <= {r_abcd[223:0], v_eff};
                end
                ST_EXP: begin
                    r_ph <= (r_ph == 3'd5) ? 3'd0 : r_ph + 3'd1;
                    case (r_ph)
                        3'd1: r_t0 <= w_rd;
                        3'd2: r_t0 <= r_t0 ^ w_rd;
                        3'd3: r_t0 <= perm1(r_t0 ^ rotl(w_rd, 5'd15));
                        3'd4: r_t1 <= rotl(w_rd, 5'd7);
                        default: ;
                    endcase
                end
                ST_RND: begin
                    r_ph <= (r_ph == 3'd2) ? 3'd0 : r_ph + 3'd1;
                    if (r_ph == 3'd1) r_t0 <= w_rd;
                    if (r_ph == 3'd2) r_abcd <= rnd_out;
                end
                ST_FOLD: if (r_idx == 7'd8) r_vinit <= 1'b0;
                ST_OUT: begin
                    if (!r_ov) begin
                        r_ov   <= 1'b1;
                        r_od   <= v_rd;
                        r_oidx <= r_oi;
                    end else if (m_axis_tready) begin
                        r_ov <= 1'b0;
                        if (r_oi == 3'd7) begin
                            // back to IV and an empty message
                            r_oi <= 3'd0; r_vinit <= 1'b1; r_cnt <= 4'd0; r_len <= 64'd0;
                            r_fin <= 1'b0; r_lenhi <= 1'b0;
                        end else r_oi <= r_oi + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_oidx, r_od};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    `SM3_ASSERT_IMPL(a_no_in_busy, r_state != ST_IDLE, !s_axis_tready)
    `SM3_ASSERT_IMPL(a_out_only_out, m_axis_tvalid, r_state == ST_OUT)
    `SM3_ASSERT_NEXT(a_rnd_to_fold, rnd_last, r_state == ST_FOLD)
endmodule
`default_nettype wire

// File: rtl/sm3_ram.sv
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module sm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/sm3_round.sv
// One SM3 compression round on the A..H working registers.
`default_nettype none
module sm3_round
    import sm3_pkg::*;
(
    input  wire logic [255:0] i_abcd,   // A in bits 255:224 ... H in bits 31:0
    input  wire logic [5:0]   i_j,
    input  wire logic [31:0]  i_w,
    input  wire logic [31:0]  i_wp,
    output logic      [255:0] o_abcd
);
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

    always_comb begin
        {a, b, c, d, e, f, g, h} = i_abcd;
        tj  = (i_j < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(a, 5'd12);
        ss1 = rotl(a12 + e + rotl(tj, i_j[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (i_j < 6'd16) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + i_wp;
        tt2 = gg + h + ss1 + i_w;
        o_abcd = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
    end
endmodule
`default_nettype wire

// File: tb/tb_sm3_hash_engine.sv
// Testbench for the SM3 hash engine: directed and random messages checked against an SM3 model.
`timescale 1ns / 1ps
`default_nettype none
module tb_sm3_hash_engine
    import sm3_pkg::*;
();

    // digest word as seen on the output stream
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // one message word request
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
    } t_msg_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    sm3_hash_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // clock, 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    localparam logic [31:0] IV [8] = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7,
        32'hda8a0600, 32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    // hash model state
    logic [31:0]  hash_cv [8];
    logic [31:0]  hash_blk [16];
    int unsigned  hash_fill;
    logic [63:0]  hash_bits;
    t_digest_word digest_q [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold = 0;

    function automatic logic [31:0] rol(input logic [31:0] x, input int k);
        k = k % 32;
        return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
    endfunction

    function automatic logic [31:0] p0f(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] p1f(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    task automatic hash_compress();
        logic [31:0] w [68];
        logic [31:0] r [8];
        logic [31:0] tj, a12, ss1, ss2, f, g, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = hash_blk[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
        for (int k = 0; k < 8; k++) r[k] = hash_cv[k];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol(r[0], 12);
            ss1 = rol(a12 + r[4] + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                f = r[0] ^ r[1] ^ r[2];
                g = r[4] ^ r[5] ^ r[6];
            end else begin
                f = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                g = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = f + r[3] + ss2 + (w[j] ^ w[j+4]);
            tt2 = g + r[7] + ss1 + w[j];
            r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
            r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4]; r[4] = p0f(tt2);
        end
        for (int k = 0; k < 8; k++) hash_cv[k] ^= r[k];
    endtask

    task automatic hash_push(input logic [31:0] v);
        hash_blk[hash_fill] = v;
        hash_fill = (hash_fill + 1) % 16;
        if (hash_fill == 0) hash_compress();
    endtask

    task automatic hash_reset();
        for (int k = 0; k < 8; k++) hash_cv[k] = IV[k];
        hash_fill = 0;
        hash_bits = '0;
    endtask

    // model one accepted request; queue digest words on the last one
    task automatic hash_take(input t_msg_word m);
        int unsigned cnt;
        logic [31:0] mask;
        t_digest_word dw;
        if (!m.last) begin
            hash_bits += 32;
            hash_push(m.word);
        end else begin
            cnt = (m.count > 4) ? 4 : m.count;
            hash_bits += cnt * 8;
            if (cnt == 4) begin
                hash_push(m.word);
                hash_push(PAD_WORD);
            end else begin
                mask = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * cnt));
                hash_push((m.word & mask) | (32'h80 << (24 - 8 * cnt)));
            end
            while (hash_fill != 14) hash_push(32'h0);
            hash_push(hash_bits[63:32]);
            hash_push(hash_bits[31:0]);
            for (int k = 0; k < 8; k++) begin
                dw = '{hash_cv[k], 3'(k), (k == 7)};
                digest_q = {digest_q, dw};
            end
            hash_reset();
        end
    endtask

    // drive one request and wait for acceptance; valid stays up for the next one
    task automatic send_word(input t_msg_word m);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, m.count, m.word};
        s_axis_tlast  <= m.last;
        do @(posedge i_clk); while (!s_axis_tready);
        hash_take(m);
    endtask

    // drop valid after the last request of a burst
    task automatic send_stop();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_message(input int nwords, input bit full_rand_count);
        t_msg_word m;
        for (int i = 0; i < nwords; i++) begin
            m.word  = $urandom;
            m.last  = (i == nwords - 1);
            m.count = (m.last || full_rand_count) ? 3'($urandom_range(7, 0)) : 3'd4;
            send_word(m);
        end
        send_stop();
    endtask

    // receiver: random ready, check against model
    always @(posedge i_clk) begin
        t_digest_word got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word, expected none, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = digest_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: digest mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d",
                                 $time, want.word, want.index, want.last,
                                 got.word, got.index, got.last);
                        errors++;
                    end
                end
            end
            m_axis_tready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        send_stop();
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // directed messages: length in words, last byte count, fill word
    localparam int DIR_N = 12;
    localparam int DIR_LEN [DIR_N] = '{1, 1, 1, 1, 1, 2, 14, 14, 15, 15, 16, 17};
    localparam int DIR_CNT [DIR_N] = '{0, 3, 4, 7, 5, 1, 2, 4, 1, 4, 2, 0};
    localparam logic [31:0] DIR_FILL [DIR_N] = '{32'hffffffff, 32'h61626300,
        32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000,
        32'hffffffff, 32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff};

    initial begin
        t_msg_word m;
        int sent;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_rst_n       = 1'b0;
        hash_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: empty message, "abc", extreme words and counts, block edges
        for (int i = 0; i < DIR_N; i++) begin
            for (int j = 0; j < DIR_LEN[i]; j++) begin
                m.last  = (j == DIR_LEN[i] - 1);
                m.word  = DIR_FILL[i];
                if (j % 3 == 1) m.word = $urandom;
                m.count = m.last ? 3'(DIR_CNT[i]) : 3'd7;
                send_word(m);
            end
        end
        wait_drained();

        // long receiver hold while the sender offers three two-word messages
        recv_hold = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                repeat (3) send_message(2, 1'b0);
            end
        join
        wait_drained();

        // random phases with idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 76 : 0;
            recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 29 : 0;
            sent = 0;
            while (sent < 20) begin
                if ($urandom_range(9, 0) == 0) begin
                    send_message(1, 1'b1);
                    sent += 1;
                end else begin
                    // mostly short messages, a few across block edges
                    int n;
                    n = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 13)
                                                    : $urandom_range(6, 1);
                    send_message(n, 1'b1);
                    sent += n;
                end
            end
            wait_drained();
        end

        repeat (600) @(posedge i_clk);
        if (errors == 0 && digest_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #80ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/sm3_pkg.sv
rtl/sm3_ram.sv
rtl/sm3_round.sv
rtl/sm3_hash_engine.sv
tb/tb_sm3_hash_engine.sv
